@@ rtl/core/spa_pkg.sv @@
`default_nettype none
// ============================================================================
// spa_pkg
// Shared types and constants for the sparse polynomial adder.
// ============================================================================
package spa_pkg;

    localparam int MAX_TERMS = 32;
    localparam int IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CNT_W     = $clog2(MAX_TERMS + 1);
    localparam int EXP_W     = 16;
    localparam int COEF_W    = 16;
    localparam int SUM_W     = COEF_W + 1;
    localparam int TERM_W    = EXP_W + COEF_W;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [1:0] {
        FUNC_LOAD_A = 2'd0,
        FUNC_LOAD_B = 2'd1,
        FUNC_START  = 2'd2
    } func_t;

endpackage
`default_nettype wire

@@ rtl/core/sparse_polynomial_add_core.sv @@
`default_nettype none
// ============================================================================
// sparse_polynomial_add_core
// Sorted-merge addition of two sparse polynomials held as term lists.
// ============================================================================
//
//  Channel   Direction  tdata                          tuser      tlast
//  s_axis    in         exponent, coefficient          func       -
//  m_axis    out        sum_exponent, sum_coefficient  has_term   last
//
//  A load word is taken while the core is idle. A start word moves the core
//  into the merge, which runs one merge step at a time (at most count_a +
//  count_b steps), then finds both lists spent and emits the final word,
//  all through one shared compare and add unit. The input is not ready
//  while a sum runs. Reset empties both lists at once; the term arrays need
//  no clearing. A stalled output holds the merge in place.
//
module sparse_polynomial_add_core
    import spa_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // exponent[15:0], coefficient[31:16]
    input  wire logic [1:0]            s_tuser,   // func[1:0]
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // sum_exponent[15:0], sum_coefficient[32:16]
    output logic                       m_tuser,   // has_term[0]
    output logic                       m_tlast
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MERGE,
        ST_FLUSH
    } state_t;

    state_t                     state_reg, state_next;
    logic [CNT_W-1:0]           count_a_reg, count_a_next;
    logic [CNT_W-1:0]           count_b_reg, count_b_next;
    logic [CNT_W-1:0]           ia_reg, ia_next;
    logic [CNT_W-1:0]           ib_reg, ib_next;
    logic                       pend_valid_reg, pend_valid_next;
    logic [EXP_W-1:0]           pend_exp_reg, pend_exp_next;
    logic signed [SUM_W-1:0]    pend_coef_reg, pend_coef_next;
    logic                       out_valid_reg, out_valid_next;
    logic [EXP_W-1:0]           out_exp_reg, out_exp_next;
    logic signed [SUM_W-1:0]    out_coef_reg, out_coef_next;
    logic                       out_has_reg, out_has_next;
    logic                       out_last_reg, out_last_next;

    logic [TERM_W-1:0]          a_terms_reg [MAX_TERMS];
    logic [TERM_W-1:0]          b_terms_reg [MAX_TERMS];

    logic                       in_accept;
    logic                       load_a;
    logic                       load_b;
    logic                       start;
    logic [TERM_W-1:0]          in_term;
    logic                       out_free;
    logic                       a_valid;
    logic                       b_valid;
    logic [TERM_W-1:0]          head_a;
    logic [TERM_W-1:0]          head_b;
    logic [EXP_W-1:0]           exp_a;
    logic [EXP_W-1:0]           exp_b;
    logic signed [SUM_W-1:0]    coef_a;
    logic signed [SUM_W-1:0]    coef_b;
    logic signed [SUM_W-1:0]    coef_sum;
    logic                       take_a;
    logic                       take_b;
    logic                       take_both;
    logic                       cand_valid;
    logic [EXP_W-1:0]           cand_exp;
    logic signed [SUM_W-1:0]    cand_coef;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign in_term   = {s_tdata[EXP_W-1:0], s_tdata[EXP_W+COEF_W-1:EXP_W]};
    assign out_free  = !out_valid_reg || m_tready;

    always_comb
    begin
        load_a = 1'b0;
        load_b = 1'b0;
        start  = 1'b0;
        unique case (s_tuser)
            FUNC_LOAD_A: load_a = in_accept && (count_a_reg < CNT_W'(MAX_TERMS));
            FUNC_LOAD_B: load_b = in_accept && (count_b_reg < CNT_W'(MAX_TERMS));
            FUNC_START:  start  = in_accept;
            default:     start  = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load_a)
        begin
            a_terms_reg[count_a_reg[IDX_W-1:0]] <= in_term;
        end
        if (load_b)
        begin
            b_terms_reg[count_b_reg[IDX_W-1:0]] <= in_term;
        end
    end

    // Shared compare and add unit over the two list heads.
    assign a_valid   = ia_reg < count_a_reg;
    assign b_valid   = ib_reg < count_b_reg;
    assign head_a    = a_terms_reg[ia_reg[IDX_W-1:0]];
    assign head_b    = b_terms_reg[ib_reg[IDX_W-1:0]];
    assign exp_a     = head_a[TERM_W-1:COEF_W];
    assign exp_b     = head_b[TERM_W-1:COEF_W];
    assign coef_a    = SUM_W'($signed(head_a[COEF_W-1:0]));
    assign coef_b    = SUM_W'($signed(head_b[COEF_W-1:0]));
    assign coef_sum  = coef_a + coef_b;
    assign take_a    = a_valid && (!b_valid || (exp_a > exp_b));
    assign take_b    = b_valid && (!a_valid || (exp_a < exp_b));
    assign take_both = a_valid && b_valid && (exp_a == exp_b);
    assign cand_valid = take_a || take_b || (take_both && (coef_sum != '0));
    assign cand_exp   = take_b ? exp_b : exp_a;
    assign cand_coef  = take_a ? coef_a : (take_b ? coef_b : coef_sum);

    always_comb
    begin
        state_next      = state_reg;
        count_a_next    = count_a_reg;
        count_b_next    = count_b_reg;
        ia_next         = ia_reg;
        ib_next         = ib_reg;
        pend_valid_next = pend_valid_reg;
        pend_exp_next   = pend_exp_reg;
        pend_coef_next  = pend_coef_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_exp_next    = out_exp_reg;
        out_coef_next   = out_coef_reg;
        out_has_next    = out_has_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (load_a)
                begin
                    count_a_next = count_a_reg + 1'b1;
                end
                if (load_b)
                begin
                    count_b_next = count_b_reg + 1'b1;
                end
                if (start)
                begin
                    ia_next         = '0;
                    ib_next         = '0;
                    pend_valid_next = 1'b0;
                    state_next      = ST_MERGE;
                end
            end
            ST_MERGE:
            begin
                if (out_free)
                begin
                    if (!a_valid && !b_valid)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        if (take_a || take_both)
                        begin
                            ia_next = ia_reg + 1'b1;
                        end
                        if (take_b || take_both)
                        begin
                            ib_next = ib_reg + 1'b1;
                        end
                        // A held term goes out only once a later term proves it is not last.
                        if (cand_valid)
                        begin
                            if (pend_valid_reg)
                            begin
                                out_valid_next = 1'b1;
                                out_exp_next   = pend_exp_reg;
                                out_coef_next  = pend_coef_reg;
                                out_has_next   = 1'b1;
                                out_last_next  = 1'b0;
                            end
                            pend_valid_next = 1'b1;
                            pend_exp_next   = cand_exp;
                            pend_coef_next  = cand_coef;
                        end
                    end
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_exp_next    = pend_valid_reg ? pend_exp_reg : '0;
                    out_coef_next   = pend_valid_reg ? pend_coef_reg : '0;
                    out_has_next    = pend_valid_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    count_a_next    = '0;
                    count_b_next    = '0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_a_reg    <= '0;
            count_b_reg    <= '0;
            ia_reg         <= '0;
            ib_reg         <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_a_reg    <= count_a_next;
            count_b_reg    <= count_b_next;
            ia_reg         <= ia_next;
            ib_reg         <= ib_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_exp_reg  <= pend_exp_next;
        pend_coef_reg <= pend_coef_next;
        out_exp_reg   <= out_exp_next;
        out_coef_reg  <= out_coef_next;
        out_has_reg   <= out_has_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_DATA_W - SUM_W - EXP_W)'(0), out_coef_reg, out_exp_reg};
    assign m_tuser  = out_has_reg;
    assign m_tlast  = out_last_reg;

`ifndef ASSERT_OFF
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_a_reg <= CNT_W'(MAX_TERMS)) && (count_b_reg <= CNT_W'(MAX_TERMS)))
        else $error("A term list count exceeds its capacity.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MERGE) |-> (ia_reg <= count_a_reg) && (ib_reg <= count_b_reg))
        else $error("A merge index ran past its list.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH && out_free) |=>
            (count_a_reg == '0) && (count_b_reg == '0) && m_tvalid && m_tlast)
        else $error("The end of a sum did not empty both lists.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tlast && (m_tdata == '0)))
        else $error("An empty-sum word is not a lone final zero word.");
`endif

endmodule
`default_nettype wire
